/* hdl/llag_pkg.sv */
// ----------------------------------------------------------------------------
// llag_pkg
// Shared types and constants for the life-like automaton grid.
// ----------------------------------------------------------------------------
package llag_pkg;

  localparam int GridSideDef = 64;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [2:0] REG_SIZE   = 3'd0;
  localparam logic [2:0] REG_SLOW   = 3'd1;
  localparam logic [2:0] REG_SHIGH  = 3'd2;
  localparam logic [2:0] REG_BLOW   = 3'd3;
  localparam logic [2:0] REG_BHIGH  = 3'd4;

  typedef enum logic [3:0] {
    ST_CLR,     // clearing sweep over both stores
    ST_IDLE,
    ST_ERD,     // edit: center read issued
    ST_EDEC,    // edit: decide on center data
    ST_NRD,     // neighbor read issued
    ST_NWR,     // neighbor write back
    ST_CPY,     // step: copy cell store to snapshot
    ST_SRD,     // step: snapshot read issued
    ST_SDEC,    // step: decide cell
    ST_RRD,     // read: data pending
    ST_OUT
  } llag_state_t;

endpackage

/* hdl/llag_mem.sv */
// ----------------------------------------------------------------------------
// llag_mem
// Single-port-write, one-read synchronous store with registered read data.
// ----------------------------------------------------------------------------
module llag_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [4:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [4:0]    rdata
);
  logic [4:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/life_like_automaton_grid_top.sv */
// ----------------------------------------------------------------------------
// life_like_automaton_grid_top
// Bounded life-like automaton; cell and snapshot stores in block memory.
//
// channel | dir | tdata (low bit first)
// in_     | in  | opcode[1:0], col[7:2], row[13:8], pad
// out_    | out | alive[0], neighbour_count[4:1], done_res[5], pad
// cfg_    | in  | index 0..4, data 7 bits
//
// Edit: center read, then decide; if the cell changes, a center write, then
// a read and a write for each of the nine neighbor slots (center unwritten).
// Step: all memory entries copied to the snapshot, then each in-grid cell read
// and decided, with the edit sequence per changing cell. Reset and active_size
// writes run a clearing sweep over every memory entry; in_tready is low until
// it ends. A result held on out_ keeps the block in its output state.
// ----------------------------------------------------------------------------
module life_like_automaton_grid_top #(
  parameter int GRID_SIDE = llag_pkg::GridSideDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode, col, row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // alive, neighbour_count, done_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import llag_pkg::*;

  localparam int SW = $clog2(GRID_SIDE);
  localparam int AW = 2 * SW;
  localparam int ZW = $clog2(GRID_SIDE + 1);
  localparam logic [AW:0] CELLS = (AW+1)'(1 << AW);

  llag_state_t st_r, st_nxt, ret_r;
  logic [ZW-1:0] size_r;
  logic [3:0] slo_r, shi_r, blo_r, bhi_r;
  logic [AW:0] ptr_r;                // sweep / copy index
  logic [6:0] rr_r, cc_r;            // current cell
  logic [6:0] sr_r, sc_r;            // step scan position
  logic [3:0] nb_r;                  // neighbor index 0..8
  logic mk_r;                        // make alive
  logic [4:0] res_r;
  logic [4:0] od_r;                  // result held on out_
  logic ov_r;

  logic c_we, s_we;
  logic [AW-1:0] c_wa, c_ra, s_wa, s_ra;
  logic [4:0] c_wd, s_wd, c_rd, s_rd;

  llag_mem #(.AW(AW)) u_cell (.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd),
                              .raddr(c_ra), .rdata(c_rd));
  llag_mem #(.AW(AW)) u_snap (.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
                              .raddr(s_ra), .rdata(s_rd));

  logic [6:0] in_col, in_row;
  assign in_col = {1'b0, in_tdata[7:2]};
  assign in_row = {1'b0, in_tdata[13:8]};

  // neighbor offset for nb_r (skips center 4)
  logic [1:0] dr, dc;
  logic [6:0] nr, nc;
  logic nin;
  always_comb begin
    unique case (nb_r)
      4'd0: {dr, dc} = 4'b0000;
      4'd1: {dr, dc} = 4'b0001;
      4'd2: {dr, dc} = 4'b0010;
      4'd3: {dr, dc} = 4'b0100;
      4'd5: {dr, dc} = 4'b0110;
      4'd6: {dr, dc} = 4'b1000;
      4'd7: {dr, dc} = 4'b1001;
      4'd8: {dr, dc} = 4'b1010;
      default: {dr, dc} = 4'b0101;
    endcase
    nr = rr_r + 7'(dr) - 7'd1;
    nc = cc_r + 7'(dc) - 7'd1;
    nin = (nb_r != 4'd4) && (nr < 7'(size_r)) && (nc < 7'(size_r));
  end

  function automatic logic [AW-1:0] addr(input logic [6:0] r, input logic [6:0] c);
    addr = {r[SW-1:0], c[SW-1:0]};
  endfunction

  logic in_fire, ein, size_wr;
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);
  assign ein = (rr_r < 7'(size_r)) && (cc_r < 7'(size_r));
  assign size_wr = cfg_we && (cfg_index == REG_SIZE);

  logic [3:0] scnt, ncnt;
  logic born, die, lastcell;
  assign scnt = s_rd[4:1];
  assign born = !s_rd[0] && (s_rd != 5'd0) && scnt >= blo_r && scnt <= bhi_r;
  assign die = s_rd[0] && (scnt < slo_r || scnt > shi_r);
  assign lastcell = (sc_r == 7'(size_r) - 7'd1) && (sr_r == 7'(size_r) - 7'd1);
  assign ncnt = mk_r ? c_rd[4:1] + 4'd1 : c_rd[4:1] - 4'd1;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (ptr_r == CELLS - 1'b1) st_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) begin
        unique case (in_tdata[1:0])
          OP_STEP: st_nxt = ST_CPY;
          OP_READ: st_nxt = ST_RRD;
          default: st_nxt = ST_ERD;
        endcase
      end
      ST_ERD:  st_nxt = ST_EDEC;
      ST_EDEC: st_nxt = (ein && (c_rd[0] != mk_r)) ? ST_NRD : ret_r;
      ST_NRD:  st_nxt = ST_NWR;
      ST_NWR:  st_nxt = (nb_r == 4'd8) ? ret_r : ST_NRD;
      ST_CPY:  if (ptr_r == CELLS) st_nxt = ST_SRD;
      ST_SRD:  st_nxt = ST_SDEC;
      ST_SDEC: st_nxt = (born || die) ? ST_ERD : (lastcell ? ST_OUT : ST_SRD);
      ST_RRD:  st_nxt = ST_OUT;
      ST_OUT:  st_nxt = (ov_r && !out_tready) ? ST_OUT : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if (size_wr) st_nxt = ST_CLR;
  end

  always_comb begin
    c_we = 1'b0; s_we = 1'b0;
    c_wa = addr(rr_r, cc_r); c_wd = 5'd0;
    s_wa = ptr_r[AW-1:0];    s_wd = 5'd0;
    c_ra = addr(rr_r, cc_r); s_ra = addr(sr_r, sc_r);
    unique case (st_r)
      ST_CLR: begin
        c_we = 1'b1; s_we = 1'b1; c_wa = ptr_r[AW-1:0];
      end
      ST_IDLE: c_ra = addr(in_row, in_col);
      ST_EDEC: begin
        c_we = ein && (c_rd[0] != mk_r);
        c_wd = {c_rd[4:1], mk_r};
      end
      ST_NRD: c_ra = addr(nr, nc);
      ST_NWR: begin
        c_we = nin; c_wa = addr(nr, nc); c_wd = {ncnt, c_rd[0]};
      end
      ST_CPY: begin
        c_ra = ptr_r[AW-1:0];
        s_we = ptr_r != '0; s_wa = AW'(ptr_r - 1'b1); s_wd = c_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR; ptr_r <= '0; ov_r <= 1'b0; od_r <= '0;
      size_r <= ZW'(GRID_SIDE < 64 ? GRID_SIDE : 64);
      slo_r <= 4'd2; shi_r <= 4'd3; blo_r <= 4'd3; bhi_r <= 4'd3;
      ret_r <= ST_OUT;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_OUT && st_nxt == ST_IDLE) begin
        ov_r <= 1'b1; od_r <= res_r;
      end else if (out_tready) ov_r <= 1'b0;
      if (size_wr) begin
        ptr_r <= '0;
      end else begin
        unique case (st_r)
          ST_CLR: ptr_r <= ptr_r + 1'b1;
          ST_IDLE: begin
            ptr_r <= '0;
            if (in_fire) begin
              rr_r <= in_row; cc_r <= in_col; mk_r <= in_tdata[0];
              sr_r <= '0; sc_r <= '0; res_r <= '0;
              ret_r <= ST_OUT;
            end
          end
          ST_EDEC: nb_r <= '0;
          ST_NWR: nb_r <= nb_r + 4'd1;
          ST_CPY: ptr_r <= ptr_r + 1'b1;
          ST_SDEC: begin
            rr_r <= sr_r; cc_r <= sc_r; mk_r <= born;
            if (sc_r == 7'(size_r) - 7'd1) begin
              sc_r <= '0; sr_r <= sr_r + 7'd1;
            end else sc_r <= sc_r + 7'd1;
            ret_r <= lastcell ? ST_OUT : ST_SRD;
          end
          ST_RRD: if (ein) res_r <= c_rd;
          default: ;
        endcase
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE: begin
            size_r <= (cfg_data == 7'd0) ? ZW'(1) :
                      (32'(cfg_data) > GRID_SIDE) ? ZW'(GRID_SIDE) : ZW'(cfg_data);
          end
          REG_SLOW:  slo_r <= cfg_data[3:0];
          REG_SHIGH: shi_r <= cfg_data[3:0];
          REG_BLOW:  blo_r <= cfg_data[3:0];
          REG_BHIGH: bhi_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {2'b00, 1'b1, od_r};
  logic unused;
  assign unused = in_tdata[14] ^ in_tdata[15];
endmodule
